// ===== src/http_date_to_epoch_parser_defines.svh =====
// Assertion macros for the HTTP date parser.
// Included by the top level; depends on nothing else.
`ifndef HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH
`define HTTP_DATE_TO_EPOCH_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hde: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hde: next-cycle check failed");

`endif

// ===== src/hde_pkg.sv =====
// Shared types, constants and lookup functions of the HTTP date parser.
// No dependencies; the parser modules and the testbench use this package.
`timescale 1ns / 1ps

package hde_pkg;

	localparam int NumDigits = 6;
	localparam int ValW      = 21;
	localparam int AccW      = 20;
	localparam int DcntW     = 3;
	localparam int EpochW    = 47;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Back-end arithmetic widths
	localparam int UW     = 21;
	localparam int QW     = 13;
	localparam int EraW   = 14;
	localparam int YoeW   = 9;
	localparam int DoyW   = 22;
	localparam int DoeW   = 23;
	localparam int DaysW  = 32;
	localparam int HmsW   = 34;
	localparam int ProdW  = 48;

	localparam int YearOffset   = 1048800;  // multiple of 400, keeps the year positive
	localparam int EraOffset    = YearOffset / 400;
	localparam int RecipDiv25   = 167773;   // ceil(2^22 / 25)
	localparam int RecipShift   = 22;
	localparam int DaysPerEra   = 146097;
	localparam int CivilShift   = 719468;
	localparam int SecPerDay    = 86400;
	localparam int SecPerHour   = 3600;
	localparam int SecPerMinute = 60;

	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharPlus  = 8'h2B;
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharColon = 8'h3A;

	localparam logic [23:0] MonthNames [12] = '{
		"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
	};

	// First day of each March-based month within the year
	localparam logic [8:0] DoyBase [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

	typedef enum logic [3:0] {
		PH_SKIP,
		PH_DAY,
		PH_MONWS,
		PH_MON,
		PH_YEAR,
		PH_HOUR,
		PH_MIN,
		PH_SEC,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic                   ok;
		logic [3:0]             month;
		logic signed [ValW-1:0] year;
		logic signed [ValW-1:0] day;
		logic signed [ValW-1:0] hour;
		logic signed [ValW-1:0] minute;
		logic signed [ValW-1:0] second;
	} date_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CharSpace) || (c >= CharTab && c <= CharCr);
	endfunction

	function automatic logic [3:0] month_index(input logic [23:0] w);
		logic [3:0] idx;
		idx = '0;
		for (int k = 0; k < 12; k++) begin
			if (w == MonthNames[k]) begin
				idx = 4'(k + 1);
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/hde_in_if.sv =====
// Text channel: one header byte per transfer with an end marker.
// Depends on nothing.
`timescale 1ns / 1ps

interface hde_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink (input valid, input text_char, input last_char, output ready);
endinterface

// ===== src/hde_out_if.sv =====
// Result channel: epoch seconds and a parse-valid flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface hde_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [46:0]       epoch_seconds;
	logic                     date_valid;

	modport source (output valid, output epoch_seconds, output date_valid, input ready);
	modport sink (input valid, input epoch_seconds, input date_valid, output ready);
endinterface

// ===== src/hde_front.sv =====
// Character parser: walks the date text one byte per cycle while the queue has room
// and emits a parsed field record on the final byte. Depends on hde_pkg and hde_in_if.
`timescale 1ns / 1ps

module hde_front
	import hde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hde_in_if.sink    text,
	input  logic      queue_full,
	output logic      push,
	output date_rec_t push_rec
);

	phase_t                 phase_q, n_phase;
	logic                   neg_q, n_neg;
	logic                   sign_q, n_sign;
	logic [DcntW-1:0]       dcnt_q, n_dcnt;
	logic [AccW-1:0]        acc_q, n_acc;
	logic signed [ValW-1:0] day_q, n_day;
	logic signed [ValW-1:0] year_q, n_year;
	logic signed [ValW-1:0] hour_q, n_hour;
	logic signed [ValW-1:0] min_q, n_min;
	logic [15:0]            letters_q, n_letters;
	logic [3:0]             month_q, n_month;
	logic                   failed_q, n_failed;

	logic                   xfer;
	logic [7:0]             ch;
	logic                   is_digit;
	logic                   ws;
	logic [3:0]             dval;
	logic [3:0]             midx;
	logic signed [ValW-1:0] num_val;

	assign ch       = text.text_char;
	assign is_digit = (ch >= CharZero) && (ch <= CharNine);
	assign ws       = is_ws(ch);
	assign dval     = 4'(ch - CharZero);
	assign midx     = month_index({letters_q, ch});
	assign num_val  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
	assign xfer     = text.valid && text.ready;

	// Next-state logic
	always_comb begin
		n_phase   = phase_q;
		n_neg     = neg_q;
		n_sign    = sign_q;
		n_dcnt    = dcnt_q;
		n_acc     = acc_q;
		n_day     = day_q;
		n_year    = year_q;
		n_hour    = hour_q;
		n_min     = min_q;
		n_letters = letters_q;
		n_month   = month_q;
		n_failed  = failed_q;
		if (!failed_q && phase_q != PH_DONE) begin
			if (ch == CharNul) begin
				// text ends here: only a seconds field with digits completes it
				if (!(phase_q == PH_SEC && dcnt_q != '0)) begin
					n_failed = 1'b1;
				end
				n_phase = PH_DONE;
			end else begin
				case (phase_q)
					PH_SKIP: begin
						if (ch == CharSpace) begin
							n_phase = PH_DAY;
						end
					end
					PH_DAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC: begin
						if (dcnt_q == '0) begin
							if (is_digit) begin
								n_dcnt = DcntW'(1);
								n_acc  = AccW'(dval);
							end else if (!sign_q && ws) begin
								n_sign = sign_q;
							end else if (!sign_q && (ch == CharPlus || ch == CharMinus)) begin
								n_sign = 1'b1;
								n_neg  = (ch == CharMinus);
							end else begin
								n_failed = 1'b1;
								n_phase  = PH_DONE;
							end
						end else if (is_digit) begin
							if (dcnt_q >= DcntW'(NumDigits)) begin
								n_failed = 1'b1;
								n_phase  = PH_DONE;
							end else begin
								n_acc  = (acc_q << 3) + (acc_q << 1) + AccW'(dval);
								n_dcnt = dcnt_q + DcntW'(1);
							end
						end else begin
							// number ends at this byte; handle the byte in the next field
							n_neg  = 1'b0;
							n_sign = 1'b0;
							n_dcnt = '0;
							n_acc  = '0;
							case (phase_q)
								PH_SEC: begin
									n_neg   = neg_q;
									n_dcnt  = dcnt_q;
									n_acc   = acc_q;
									n_phase = PH_DONE;
								end
								PH_DAY: begin
									n_day = num_val;
									if (ws) begin
										n_phase = PH_MONWS;
									end else begin
										n_letters = {8'h00, ch};
										n_dcnt    = DcntW'(1);
										n_phase   = PH_MON;
									end
								end
								PH_YEAR: begin
									n_year  = num_val;
									n_phase = PH_HOUR;
									if (ch == CharPlus || ch == CharMinus) begin
										n_sign = 1'b1;
										n_neg  = (ch == CharMinus);
									end else if (!ws) begin
										n_failed = 1'b1;
										n_phase  = PH_DONE;
									end
								end
								PH_HOUR: begin
									n_hour = num_val;
									if (ch == CharColon) begin
										n_phase = PH_MIN;
									end else begin
										n_failed = 1'b1;
										n_phase  = PH_DONE;
									end
								end
								PH_MIN: begin
									n_min = num_val;
									if (ch == CharColon) begin
										n_phase = PH_SEC;
									end else begin
										n_failed = 1'b1;
										n_phase  = PH_DONE;
									end
								end
								default: begin
									n_phase = phase_q;
								end
							endcase
						end
					end
					PH_MONWS: begin
						if (!ws) begin
							n_letters = {8'h00, ch};
							n_dcnt    = DcntW'(1);
							n_phase   = PH_MON;
						end
					end
					PH_MON: begin
						if (ws) begin
							n_failed = 1'b1;
							n_phase  = PH_DONE;
						end else if (dcnt_q >= DcntW'(2)) begin
							if (midx == '0) begin
								n_failed = 1'b1;
								n_phase  = PH_DONE;
							end else begin
								n_month = midx;
								n_phase = PH_YEAR;
								n_dcnt  = '0;
							end
						end else begin
							n_letters = {letters_q[7:0], ch};
							n_dcnt    = dcnt_q + DcntW'(1);
						end
					end
					default: begin
						n_phase = phase_q;
					end
				endcase
			end
		end
	end

	// Outputs
	always_comb begin
		text.ready      = !queue_full;
		push            = xfer && text.last_char;
		push_rec.ok     = !n_failed && (n_phase == PH_DONE ||
			(n_phase == PH_SEC && n_dcnt != '0));
		push_rec.month  = n_month;
		push_rec.year   = n_year;
		push_rec.day    = n_day;
		push_rec.hour   = n_hour;
		push_rec.minute = n_min;
		push_rec.second = n_neg ? -$signed({1'b0, n_acc}) : $signed({1'b0, n_acc});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			neg_q     <= 1'b0;
			sign_q    <= 1'b0;
			dcnt_q    <= '0;
			acc_q     <= '0;
			day_q     <= '0;
			year_q    <= '0;
			hour_q    <= '0;
			min_q     <= '0;
			letters_q <= '0;
			month_q   <= '0;
			failed_q  <= 1'b0;
		end else if (xfer) begin
			if (text.last_char) begin
				// header done: start over for the next one
				phase_q   <= PH_SKIP;
				neg_q     <= 1'b0;
				sign_q    <= 1'b0;
				dcnt_q    <= '0;
				acc_q     <= '0;
				day_q     <= '0;
				year_q    <= '0;
				hour_q    <= '0;
				min_q     <= '0;
				letters_q <= '0;
				month_q   <= '0;
				failed_q  <= 1'b0;
			end else begin
				phase_q   <= n_phase;
				neg_q     <= n_neg;
				sign_q    <= n_sign;
				dcnt_q    <= n_dcnt;
				acc_q     <= n_acc;
				day_q     <= n_day;
				year_q    <= n_year;
				hour_q    <= n_hour;
				min_q     <= n_min;
				letters_q <= n_letters;
				month_q   <= n_month;
				failed_q  <= n_failed;
			end
		end
	end

endmodule

// ===== src/hde_queue.sv =====
// Short queue of parsed date records between parser and epoch pipeline.
// Depends on hde_pkg.
`timescale 1ns / 1ps

module hde_queue
	import hde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  date_rec_t push_rec,
	input  logic      pop,
	output date_rec_t pop_rec,
	output qstat_t    stat
);

	date_rec_t            mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 :
					wr_ptr_q + QueuePtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 :
					rd_ptr_q + QueuePtrW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
				2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	assign pop_rec    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QueueCntW'(QueueDepth));
	assign stat.empty = (cnt_q == '0);

endmodule

// ===== src/hde_back.sv =====
// Epoch pipeline: turns a parsed date record into Unix seconds over six
// stages plus an output register. Depends on hde_pkg and hde_out_if.
`timescale 1ns / 1ps

module hde_back
	import hde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  date_rec_t head,
	input  qstat_t    qstat,
	output logic      pop,
	hde_out_if.source result
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic out_valid_q;
	logic signed [EpochW-1:0] epoch_q;
	logic date_valid_q;

	// stage 1
	logic                   m_early;
	logic [3:0]             mp;
	logic signed [ValW-1:0] y_adj;
	logic [UW-1:0]          u_c;
	logic signed [DoyW-1:0] doy_c;
	logic signed [HmsW-1:0] hours_c, mins_c;
	logic [UW-1:0]          u_s1;
	logic signed [DoyW-1:0] doy_s1;
	logic signed [HmsW-1:0] hours_s1, mins_s1;
	logic signed [ValW-1:0] sec_s1;

	// stage 2
	logic [34:0]            qprod;
	logic signed [HmsW-1:0] hms_c;
	logic [QW-1:0]          q_s2;
	logic [UW-1:0]          u_s2;
	logic signed [DoyW-1:0] doy_s2;
	logic signed [HmsW-1:0] hms_s2;

	// stage 3
	logic [UW-1:0]          yoe_full;
	logic [YoeW-1:0]        yoe_s3;
	logic signed [EraW-1:0] era_s3;
	logic signed [DoyW-1:0] doy_s3;
	logic signed [HmsW-1:0] hms_s3;

	// stage 4
	logic [1:0]              c100;
	logic signed [DoeW-1:0]  doe_c;
	logic signed [DaysW-1:0] era_days_c;
	logic signed [DoeW-1:0]  doe_s4;
	logic signed [DaysW-1:0] era_days_s4;
	logic signed [HmsW-1:0]  hms_s4;

	// stages 5, 6 and output
	logic signed [DaysW-1:0] days_s5;
	logic signed [HmsW-1:0]  hms_s5;
	logic signed [ProdW-1:0] prod_s6;
	logic signed [HmsW-1:0]  hms_s6;
	logic signed [ProdW-1:0] total;

	// the whole pipe moves when the output register is free
	assign adv = !out_valid_q || result.ready;
	assign pop = adv && !qstat.empty;

	assign m_early = (head.month <= 4'd2);
	assign mp      = m_early ? head.month + 4'd9 : head.month - 4'd3;
	assign y_adj   = head.year - (m_early ? ValW'(1) : ValW'(0));
	assign u_c     = UW'($signed({y_adj[ValW-1], y_adj}) + (ValW + 1)'(YearOffset));
	assign doy_c   = $signed({1'b0, {(DoyW - 10){1'b0}}, DoyBase[mp]}) + DoyW'(head.day) -
		DoyW'(1);
	assign hours_c = HmsW'(head.hour) * HmsW'(SecPerHour);
	assign mins_c  = HmsW'(head.minute) * HmsW'(SecPerMinute);

	// floor(u / 400) as (u >> 4) / 25 by reciprocal multiply
	assign qprod = 35'(u_s1[UW-1:4]) * 35'(RecipDiv25);
	assign hms_c = hours_s1 + mins_s1 + HmsW'(sec_s1);

	assign yoe_full = u_s2 - UW'(q_s2) * UW'(400);

	always_comb begin
		if (yoe_s3 >= YoeW'(300)) begin
			c100 = 2'd3;
		end else if (yoe_s3 >= YoeW'(200)) begin
			c100 = 2'd2;
		end else if (yoe_s3 >= YoeW'(100)) begin
			c100 = 2'd1;
		end else begin
			c100 = 2'd0;
		end
	end

	assign doe_c = DoeW'($signed({1'b0, yoe_s3})) * DoeW'(365) +
		DoeW'($signed({1'b0, yoe_s3[YoeW-1:2]})) - DoeW'($signed({1'b0, c100})) +
		DoeW'(doy_s3);
	assign era_days_c = DaysW'(era_s3) * DaysW'(DaysPerEra);
	assign total      = prod_s6 + ProdW'(hms_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !qstat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1    <= head.ok;
			u_s1     <= u_c;
			doy_s1   <= doy_c;
			hours_s1 <= hours_c;
			mins_s1  <= mins_c;
			sec_s1   <= head.second;

			ok_s2  <= ok_s1;
			q_s2   <= qprod[34:RecipShift];
			u_s2   <= u_s1;
			doy_s2 <= doy_s1;
			hms_s2 <= hms_c;

			ok_s3  <= ok_s2;
			yoe_s3 <= yoe_full[YoeW-1:0];
			era_s3 <= $signed({1'b0, q_s2}) - EraW'(EraOffset);
			doy_s3 <= doy_s2;
			hms_s3 <= hms_s2;

			ok_s4       <= ok_s3;
			doe_s4      <= doe_c;
			era_days_s4 <= era_days_c;
			hms_s4      <= hms_s3;

			ok_s5   <= ok_s4;
			days_s5 <= era_days_s4 + DaysW'(doe_s4) - DaysW'(CivilShift);
			hms_s5  <= hms_s4;

			ok_s6   <= ok_s5;
			prod_s6 <= ProdW'(days_s5) * ProdW'(SecPerDay);
			hms_s6  <= hms_s5;

			// a failed parse reports zero seconds
			epoch_q      <= ok_s6 ? total[EpochW-1:0] : '0;
			date_valid_q <= ok_s6;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.epoch_seconds = epoch_q;
	assign result.date_valid    = date_valid_q;

endmodule

// ===== src/http_date_to_epoch_parser.sv =====
// HTTP Date header to Unix epoch: one text byte per cycle while the record
// queue has room. A record passes through the parser, the record queue,
// six arithmetic stages and the output register on its way to a result.
// Throughput: up to one byte per cycle in and up to one result per cycle out.
// The 4-entry record queue lets the parser keep going while results stall.
// arst_n clears parser state, queue and pipeline valids at once.
`timescale 1ns / 1ps
`include "http_date_to_epoch_parser_defines.svh"

module http_date_to_epoch_parser
	import hde_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	hde_in_if.sink    text,
	hde_out_if.source result
);

	logic      push;
	logic      pop;
	date_rec_t push_rec;
	date_rec_t head;
	qstat_t    qstat;

	hde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.queue_full (qstat.full),
		.push       (push),
		.push_rec   (push_rec)
	);

	hde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (head),
		.stat     (qstat)
	);

	hde_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	`HDE_ASSERT_IMP(a_fail_gives_zero, clk, arst_n, (result.valid && !result.date_valid), (result.epoch_seconds == '0))
	`HDE_ASSERT_IMP(a_pop_needs_entry, clk, arst_n, pop, !qstat.empty)
	`HDE_ASSERT_NXT(a_last_queues_record, clk, arst_n, (text.valid && text.ready && text.last_char), !qstat.empty)

endmodule

// ===== sim/tb_top.sv =====
// Testbench for http_date_to_epoch_parser: streams Date header text in, predicts each
// epoch result in a scoreboard class and compares every result transfer field by field.
// Depends on hde_pkg, hde_in_if, hde_out_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int CycleLimit = 400000;
	localparam int BodyChars  = 1750;
	localparam int ReportMax  = 10;

	localparam logic [7:0] Blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	typedef enum int {
		SCAN_SKIP,
		SCAN_DAY,
		SCAN_MONWS,
		SCAN_MON,
		SCAN_YEAR,
		SCAN_HOUR,
		SCAN_COL1,
		SCAN_MIN,
		SCAN_COL2,
		SCAN_SEC,
		SCAN_DONE
	} scan_step_t;

	class epoch_scoreboard;
		typedef struct {
			logic [46:0] epoch;
			logic        ok;
		} date_result_t;

		date_result_t expected_q[$];
		int errors;

		scan_step_t  step;
		bit          neg;
		bit          sign_taken;
		int          ndig;
		int          acc;
		int          day_v;
		int          year_v;
		int          hour_v;
		int          min_v;
		logic [23:0] mon_letters;
		bit          failed;

		function new();
			errors = 0;
			clear();
		endfunction

		function void restart_number();
			neg = 0;
			sign_taken = 0;
			ndig = 0;
			acc = 0;
		endfunction

		function void clear();
			step = SCAN_SKIP;
			restart_number();
			day_v = 0;
			year_v = 0;
			hour_v = 0;
			min_v = 0;
			mon_letters = '0;
			failed = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == hde_pkg::CharSpace || (c >= hde_pkg::CharTab && c <= hde_pkg::CharCr);
		endfunction

		function int month_number(logic [23:0] w);
			case (w)
				"Jan": return 1;
				"Feb": return 2;
				"Mar": return 3;
				"Apr": return 4;
				"May": return 5;
				"Jun": return 6;
				"Jul": return 7;
				"Aug": return 8;
				"Sep": return 9;
				"Oct": return 10;
				"Nov": return 11;
				"Dec": return 12;
				default: return 0;
			endcase
		endfunction

		function void abort();
			failed = 1;
			step = SCAN_DONE;
		endfunction

		function int num_value();
			return neg ? -acc : acc;
		endfunction

		// Returns 1 when c closes the number; c then goes to the next field.
		function bit number_char(logic [7:0] c);
			bit digit;
			digit = c >= hde_pkg::CharZero && c <= hde_pkg::CharNine;
			if (ndig == 0) begin
				if (digit) begin
					ndig = 1;
					acc = int'(c - hde_pkg::CharZero);
				end else if (!sign_taken && is_blank(c)) begin
				end else if (!sign_taken && (c == hde_pkg::CharPlus || c == hde_pkg::CharMinus)) begin
					sign_taken = 1;
					neg = (c == hde_pkg::CharMinus);
				end else begin
					abort();
				end
				return 0;
			end
			if (!digit)
				return 1;
			if (ndig >= hde_pkg::NumDigits) begin
				abort();
				return 0;
			end
			acc = acc * 10 + int'(c - hde_pkg::CharZero);
			ndig++;
			return 0;
		endfunction

		function void scan_char(logic [7:0] c);
			bit again;
			again = 1;
			while (again) begin
				again = 0;
				case (step)
					SCAN_SKIP: begin
						if (c == hde_pkg::CharSpace) begin
							step = SCAN_DAY;
							restart_number();
						end
					end
					SCAN_DAY, SCAN_YEAR, SCAN_HOUR, SCAN_MIN, SCAN_SEC: begin
						if (number_char(c)) begin
							case (step)
								SCAN_DAY: begin
									day_v = num_value();
									step = SCAN_MONWS;
								end
								SCAN_YEAR: begin
									year_v = num_value();
									step = SCAN_HOUR;
								end
								SCAN_HOUR: begin
									hour_v = num_value();
									step = SCAN_COL1;
								end
								SCAN_MIN: begin
									min_v = num_value();
									step = SCAN_COL2;
								end
								default: step = SCAN_DONE;
							endcase
							// keep the seconds value, hand c to the next field otherwise
							if (step != SCAN_DONE) begin
								restart_number();
								again = 1;
							end
						end
					end
					SCAN_MONWS: begin
						if (!is_blank(c)) begin
							mon_letters = {16'h0000, c};
							ndig = 1;
							step = SCAN_MON;
						end
					end
					SCAN_MON: begin
						if (is_blank(c)) begin
							abort();
						end else begin
							mon_letters = {mon_letters[15:0], c};
							ndig++;
							if (ndig >= 3) begin
								if (month_number(mon_letters) == 0) begin
									abort();
								end else begin
									step = SCAN_YEAR;
									restart_number();
								end
							end
						end
					end
					SCAN_COL1, SCAN_COL2: begin
						if (c != hde_pkg::CharColon) begin
							abort();
						end else begin
							step = (step == SCAN_COL1) ? SCAN_MIN : SCAN_SEC;
							restart_number();
						end
					end
					default: ;
				endcase
			end
		endfunction

		function void finish_text();
			if (failed || step == SCAN_DONE)
				return;
			if (step == SCAN_SEC && ndig > 0)
				step = SCAN_DONE;
			else
				abort();
		endfunction

		function void note_text(logic [7:0] c, logic last);
			date_result_t r;
			longint m, y, era, yoe, doy, doe, days, secs;
			if (!failed && step != SCAN_DONE) begin
				if (c == hde_pkg::CharNul) begin
					finish_text();
					step = SCAN_DONE;
				end else begin
					scan_char(c);
				end
			end
			if (!last)
				return;
			finish_text();
			secs = 0;
			if (!failed) begin
				// days from civil date, March-based year
				m = month_number(mon_letters);
				y = longint'(year_v) - ((m <= 2) ? 1 : 0);
				era = ((y >= 0) ? y : y - 399) / 400;
				yoe = y - era * 400;
				doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + longint'(day_v) - 1;
				doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
				days = era * 146097 + doe - 719468;
				secs = days * 86400 + longint'(hour_v) * 3600 + longint'(min_v) * 60
					+ longint'(num_value());
			end
			r.epoch = secs[46:0];
			r.ok = !failed;
			expected_q.push_back(r);
			clear();
		endfunction

		function void check_result(logic [46:0] epoch, logic ok);
			date_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= ReportMax)
					$display("unexpected result: epoch=%0d valid=%0b", $signed(epoch), ok);
				return;
			end
			e = expected_q.pop_front();
			if (e.epoch !== epoch || e.ok !== ok) begin
				errors++;
				if (errors <= ReportMax)
					$display("mismatch: expected epoch=%0d valid=%0b, got epoch=%0d valid=%0b",
						$signed(e.epoch), e.ok, $signed(epoch), ok);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   tx_max_gap;
	int   rx_max_gap;
	int   sent_chars;

	logic [7:0] header_q[$];

	string directed_text[19] = '{
		"Sun, 06 Nov 1994 08:49:37 GMT",
		"Thu, 01 Jan 1970 00:00:00 GMT",
		"Tue, 29 Feb 2000 23:59:59 GMT",
		"x -999999 Dec -999999 -999999:-999999:-999999",
		"x 999999 Jan 999999 999999:999999:999999",
		"NoSpaceAtAll",
		"x 1234567 Jan 2000 00:00:00",
		"x + Jan 2000 1:2:3",
		"x 5 Ja",
		"x 5 Ja 2000 1:2:3",
		"x 5 jan 2000 1:2:3",
		"x 5 Jan 2000 1 :2:3",
		"x 5 Jan 2000 1:2",
		"x 5 Jun 2000 1:2:",
		"x 7Mar0 0:0:0",
		"x 1 Feb -1 -0:+0:-1 junk",
		"A",
		" ",
		"x 31 Dec 2100 23:59:60"
	};

	string weekdays[4] = '{"Sun,", "Tue,", "Wednesday,", "Fri"};

	epoch_scoreboard sb = new();

	hde_in_if  text_ch ();
	hde_out_if result_ch ();

	http_date_to_epoch_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		return ($urandom_range(2, 0) == 0) ? 0 : 19;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			header_q.push_back(s[i]);
	endfunction

	function automatic void add_blanks(int most);
		int n;
		n = $urandom_range(most, 0);
		repeat (n) header_q.push_back(Blanks[$urandom_range(5, 0)]);
	endfunction

	function automatic void add_number(int lo, int hi);
		int sel;
		int nd;
		add_blanks(2);
		sel = $urandom_range(7, 0);
		if (sel == 0)
			header_q.push_back(hde_pkg::CharPlus);
		else if (sel == 1)
			header_q.push_back(hde_pkg::CharMinus);
		if ($urandom_range(1, 0) == 0) begin
			add_text($sformatf("%02d", $urandom_range(hi, lo)));
		end else begin
			nd = ($urandom_range(99, 0) < 4) ? 7 : $urandom_range(6, 1);
			repeat (nd) header_q.push_back(hde_pkg::CharZero + 8'($urandom_range(9, 0)));
		end
	endfunction

	function automatic void build_header();
		logic [23:0] name;
		int k;
		header_q.delete();
		add_text(weekdays[$urandom_range(3, 0)]);
		header_q.push_back(hde_pkg::CharSpace);
		add_number(1, 31);
		add_blanks(2);
		name = hde_pkg::MonthNames[$urandom_range(11, 0)];
		k = $urandom_range(9, 0);
		// flip the case of one letter, or cut the name short
		if (k == 0)
			name[8 * $urandom_range(2, 0) +: 8] ^= 8'h20;
		if (k == 1) begin
			header_q.push_back(name[23:16]);
			header_q.push_back(name[15:8]);
			header_q.push_back(hde_pkg::CharSpace);
		end else begin
			header_q.push_back(name[23:16]);
			header_q.push_back(name[15:8]);
			header_q.push_back(name[7:0]);
		end
		add_blanks(2);
		add_number(1900, 2100);
		header_q.push_back(hde_pkg::CharSpace);
		add_number(0, 23);
		header_q.push_back(hde_pkg::CharColon);
		add_number(0, 59);
		header_q.push_back(hde_pkg::CharColon);
		add_number(0, 60);
		k = $urandom_range(3, 0);
		if (k == 0)
			add_text(" GMT");
		else if (k == 1)
			repeat ($urandom_range(4, 1)) header_q.push_back(8'($urandom_range(255, 0)));
	endfunction

	function automatic void break_header();
		int k;
		k = $urandom_range(2, 0);
		if (k == 0)
			header_q = header_q[0:$urandom_range(header_q.size() - 1, 0)];
		else if (k == 1)
			header_q[$urandom_range(header_q.size() - 1, 0)] = 8'($urandom_range(255, 0));
		else
			header_q.insert($urandom_range(header_q.size() - 1, 0), hde_pkg::CharNul);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = $urandom_range(tx_max_gap, 0);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_char <= c;
		text_ch.last_char <= last;
		do @(posedge clk); while (!text_ch.ready);
		sb.note_text(c, last);
		sent_chars++;
	endtask

	task automatic send_header();
		for (int i = 0; i < header_q.size(); i++)
			send_char(header_q[i], i == header_q.size() - 1);
	endtask

	task automatic send_text(input string s);
		header_q.delete();
		add_text(s);
		send_header();
	endtask

	// Drop valid and hold until every expected result has come back.
	task automatic hold_until_drained();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			int stall;
			stall = $urandom_range(rx_max_gap, 0);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			sb.check_result(result_ch.epoch_seconds, result_ch.date_valid);
		end
	end

	initial begin
		int kind;
		int headers;
		int pause_at;
		arst_n            = 1'b0;
		cycles            = 0;
		tx_max_gap        = 0;
		rx_max_gap        = 0;
		sent_chars        = 0;
		text_ch.valid     = 1'b0;
		text_ch.text_char = '0;
		text_ch.last_char = 1'b0;
		headers           = 0;
		pause_at          = $urandom_range(40, 10);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_text[i]) begin
			tx_max_gap = pick_gap();
			rx_max_gap = pick_gap();
			send_text(directed_text[i]);
		end
		// text ends at a NUL after the seconds, then at a NUL before the year
		header_q.delete();
		add_text("Sun, 06 Nov 1994 08:49:37");
		header_q.push_back(hde_pkg::CharNul);
		add_text("zz");
		send_header();
		header_q.delete();
		add_text("Sun, 06 Nov");
		header_q.push_back(hde_pkg::CharNul);
		add_text(" 1994 08:49:37");
		send_header();
		// every kind of blank, signs and high bytes in the trailer
		header_q.delete();
		add_text("x \t\n+7");
		header_q.push_back(8'h0B);
		header_q.push_back(8'h0C);
		add_text("Apr\r\n-2001 +3:-4:");
		header_q.push_back(8'h0C);
		add_text("5");
		header_q.push_back(8'hFF);
		header_q.push_back(8'h80);
		send_header();
		hold_until_drained();

		while (sent_chars < BodyChars) begin
			tx_max_gap = pick_gap();
			rx_max_gap = pick_gap();
			kind = $urandom_range(99, 0);
			if (kind < 15) begin
				header_q.delete();
				repeat ($urandom_range(12, 1)) header_q.push_back(8'($urandom_range(255, 0)));
			end else begin
				build_header();
				if (kind < 35)
					break_header();
			end
			send_header();
			headers++;
			if (headers == pause_at)
				hold_until_drained();
		end

		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
